// ----- hw/rtl/dct8q_pkg.sv -----
// shared types, constants and cosine/zigzag tables for the residual dct quantizer
package dct8q_pkg;

  // fixed point setup
  localparam int COS_FRAC  = 14;
  localparam int ROW_FRAC  = 12;
  localparam int COS_W     = COS_FRAC + 2;
  localparam int OPND_W    = 24;
  localparam int PROD_W    = OPND_W + COS_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int NUM_W     = ACC_W + COS_W;
  localparam int QSH       = 14 + 2 * COS_FRAC;
  localparam int T_W       = NUM_W + 1 - QSH;
  localparam int DCNT_W    = $clog2(T_W + 1);
  localparam int ROW_RSH   = (COS_FRAC > ROW_FRAC) ? COS_FRAC - ROW_FRAC : 0;
  localparam int ROW_LSH   = (COS_FRAC < ROW_FRAC) ? ROW_FRAC - COS_FRAC : 0;
  localparam longint ROW_RND = (ROW_RSH > 0) ? (64'd1 << (ROW_RSH - 1)) : 0;
  localparam logic [31:0] COS_RND = 32'(64'd1 << (29 - COS_FRAC));

  localparam logic signed [12:0] COEF_MAX = 13'sd4095;
  localparam logic signed [12:0] COEF_MIN = -13'sd4096;
  localparam logic [63:0] QUANT_RESET = 64'h0101010101010101;
  localparam int NUM_QWORDS = 8;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] predicted;
  } in_beat_t;

  typedef struct packed {
    logic signed [12:0] coefficient;
    logic [5:0]         zigzag_position;
    logic               block_end;
  } out_beat_t;

  // residual write from the front into the back's two-bank store
  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [8:0] data;
  } res_wr_t;

  // block finished in the back, its bank is free again
  typedef struct packed {
    logic done;
    logic bank;
  } blk_rel_t;

  localparam logic [31:0] COS_Q30 [9] = '{
    32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
    32'd596538995, 32'd410903207, 32'd209476638, 32'd0
  };

  localparam logic [5:0] ZZ_TO_RASTER [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // cos((2k+1)f*pi/16) in Q(COS_FRAC)
  function automatic logic signed [COS_W-1:0] cos_fixed(input logic [2:0] k,
                                                         input logic [2:0] f);
    logic [6:0]  pm;
    logic [4:0]  m;
    logic        neg;
    logic [31:0] mag;
    pm  = 7'({k, 1'b1}) * 7'(f);
    m   = pm[4:0];
    neg = 1'b0;
    if (m > 5'd16) m = 5'(6'd32 - {1'b0, m});
    if (m > 5'd8) begin
      m   = 5'd16 - m;
      neg = 1'b1;
    end
    mag = (COS_Q30[m[3:0]] + COS_RND) >> (30 - COS_FRAC);
    return neg ? -$signed(COS_W'(mag)) : $signed(COS_W'(mag));
  endfunction

  // dc row/column scale weight
  function automatic logic signed [COS_W-1:0] dc_weight(input logic [2:0] u,
                                                         input logic [2:0] v);
    if (u == 3'd0 && v == 3'd0) return $signed(COS_W'(1) << (COS_FRAC - 1));
    if (u == 3'd0 || v == 3'd0) return cos_fixed(3'd0, 3'd4);
    return $signed(COS_W'(1) << COS_FRAC);
  endfunction

endpackage

// ----- hw/rtl/residual_dct8x8_quantizer_top.sv -----
// per coefficient: an 8-tap column mac plus an 18-step divider, skipped for a zero
//   quantizer entry; while the back works on one block the front fills the other bank
// input takes one beat per cycle until both residual banks are owned by the back
// reset: synchronous active-high rst clears counters, queue, sequencer and sets
//   all quantizer entries to 1
module residual_dct8x8_quantizer_top import dct8q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   coef,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  res_wr_t  rw;
  blk_rel_t rel;
  logic     q_push;
  logic     q_push_bank;
  logic     q_pop;
  logic     q_head;
  logic     q_empty;
  logic     q_full;

  dct8q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .rw        (rw),
    .push      (q_push),
    .push_bank (q_push_bank),
    .rel       (rel)
  );

  dct8q_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_bank (q_push_bank),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dct8q_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rw        (rw),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rel       (rel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coef      (coef)
  );

  // block queue never overflows or underflows
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("block queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("block queue pop while empty");

  // last beat of a block carries the last zigzag position
  a_block_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coef.block_end == (coef.zigzag_position == 6'd63)))
    else $error("block_end does not match zigzag position");

endmodule

// ----- hw/rtl/dct8q_front.sv -----
// front end: takes sample beats, forms residuals, hands full blocks to the back
module dct8q_front import dct8q_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  output res_wr_t  rw,
  output logic     push,
  output logic     push_bank,
  input  blk_rel_t rel
);

  logic       wr_bank;
  logic [5:0] count;
  logic [1:0] busy;
  logic       acc_beat;

  // a bank still owned by the back blocks the input side
  assign in_stall  = busy[wr_bank];
  assign acc_beat  = in_valid && !in_stall;
  assign rw.en     = acc_beat;
  assign rw.addr   = {wr_bank, count};
  assign rw.data   = {1'b0, in_data.pixel} - {1'b0, in_data.predicted};
  assign push      = acc_beat && (count == 6'd63);
  assign push_bank = wr_bank;

  // sample counter and bank ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank <= 1'b0;
      count   <= '0;
      busy    <= '0;
    end else begin
      if (rel.done) busy[rel.bank] <= 1'b0;
      if (acc_beat) begin
        count <= count + 6'd1;
        if (count == 6'd63) begin
          busy[wr_bank] <= 1'b1;
          wr_bank       <= ~wr_bank;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dct8q_queue.sv -----
// two-entry queue of finished block banks between front and back
module dct8q_queue import dct8q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_bank,
  input  logic pop,
  output logic head,
  output logic empty,
  output logic full
);

  logic [1:0] slot;
  logic       wp;
  logic       rp;
  logic [1:0] level;

  assign head  = slot[rp];
  assign empty = (level == 2'd0);
  assign full  = (level == 2'd2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      level <= '0;
    end else begin
      if (push) begin
        slot[wp] <= push_bank;
        wp       <= ~wp;
      end
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dct8q_back.sv -----
// back end: row/column dct on one mac, quantizing divider, zigzag output register
module dct8q_back import dct8q_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_wr_t   rw,
  input  logic      q_empty,
  input  logic      q_head,
  output logic      q_pop,
  output blk_rel_t  rel,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t coef
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_DRAIN, S_COL, S_CWAIT, S_MUL, S_PREP, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [8:0] res_mem [128];
  logic signed [OPND_W-1:0] tr_mem [64];
  logic [63:0] quant [NUM_QWORDS];

  logic       bank;
  logic [8:0] cnt;
  logic [5:0] z;
  logic [5:0] zr;
  logic [2:0] zu;
  logic [2:0] zv;
  logic [7:0] q;
  logic       issue;

  logic [8:0]               res_rd;
  logic signed [OPND_W-1:0] tr_rd;

  logic       p1_vld, p1_first, p1_last, p1_col;
  logic [2:0] p1_k, p1_f;
  logic [5:0] p1_dst;
  logic       p2_vld, p2_first, p2_last, p2_col;
  logic [5:0] p2_dst;
  logic signed [PROD_W-1:0] prod;
  logic       p3_done, p3_col;
  logic [5:0] p3_dst;
  logic signed [ACC_W-1:0] acc;

  logic signed [OPND_W-1:0] opnd;
  logic signed [COS_W-1:0]  cosv;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W:0]          tsum;
  logic       neg, nzero, qz;
  logic [T_W-1:0]    quo;
  logic [7:0]        rem;
  logic [DCNT_W-1:0] dcnt;
  logic [8:0]        rem_sh;
  logic              ge;
  logic [12:0]       negr;
  logic signed [12:0] sat;

  // rounds a row sum to the transpose format
  function automatic logic signed [OPND_W-1:0] row_round(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] m;
    m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    m = (m + ACC_W'(ROW_RND)) >> ROW_RSH;
    m = m << ROW_LSH;
    return a[ACC_W-1] ? -$signed(OPND_W'(m)) : $signed(OPND_W'(m));
  endfunction

  assign zr    = ZZ_TO_RASTER[z];
  assign zv    = zr[5:3];
  assign zu    = zr[2:0];
  assign q     = quant[z[5:3]][{z[2:0], 3'b000} +: 8];
  assign issue = (state == S_ROW) || (state == S_COL);
  assign q_pop = (state == S_IDLE) && !q_empty;

  assign opnd = p1_col ? tr_rd : OPND_W'($signed(res_rd));
  assign cosv = cos_fixed(p1_k, p1_f);

  assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign tsum = {1'b0, mag} + ((NUM_W + 1)'(q) << (QSH - 1));

  // one restoring divider step
  assign rem_sh = {rem, quo[T_W-1]};
  assign ge     = rem_sh >= {1'b0, q};

  // saturation of the quotient
  assign negr = 13'd0 - quo[12:0];
  always_comb begin
    if (qz) begin
      if (!nzero) sat = '0;
      else        sat = neg ? COEF_MIN : COEF_MAX;
    end else if (neg) begin
      sat = (quo > T_W'(4096)) ? COEF_MIN : $signed(negr);
    end else begin
      sat = (quo > T_W'(4095)) ? COEF_MAX : $signed(quo[12:0]);
    end
  end

  // quantizer register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QWORDS; i++) quant[i] <= QUANT_RESET;
    end else if (cfg_we) begin
      quant[cfg_index] <= cfg_data;
    end
  end

  // residual store, two banks
  always_ff @(posedge clk) begin
    if (rw.en) res_mem[rw.addr] <= rw.data;
    res_rd <= res_mem[{bank, cnt[8:6], cnt[2:0]}];
  end

  // transpose store
  always_ff @(posedge clk) begin
    if (p3_done && !p3_col) tr_mem[p3_dst] <= row_round(acc);
    tr_rd <= tr_mem[{zu, cnt[2:0]}];
  end

  // sequencer, mac pipeline, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      p3_done   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      z         <= '0;
      bank      <= 1'b0;
      rel       <= '0;
    end else begin
      // bank release pulse once the last beat of a block is taken
      rel.done <= (state == S_OUT) && !out_stall && (z == 6'd63);

      // mac stage 1: read issued, tags follow
      p1_vld   <= issue;
      p1_k     <= cnt[2:0];
      p1_f     <= (state == S_ROW) ? cnt[5:3] : zv;
      p1_first <= (cnt[2:0] == 3'd0);
      p1_last  <= (cnt[2:0] == 3'd7);
      p1_dst   <= {cnt[5:3], cnt[8:6]};
      p1_col   <= (state == S_COL);

      // mac stage 2: product
      p2_vld   <= p1_vld;
      p2_first <= p1_first;
      p2_last  <= p1_last;
      p2_dst   <= p1_dst;
      p2_col   <= p1_col;
      prod     <= opnd * cosv;

      // mac stage 3: accumulate
      p3_done <= p2_vld && p2_last;
      p3_dst  <= p2_dst;
      p3_col  <= p2_col;
      if (p2_vld) acc <= p2_first ? ACC_W'(prod) : acc + ACC_W'(prod);

      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            bank  <= q_head;
            cnt   <= '0;
            z     <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          cnt <= cnt + 9'd1;
          if (cnt == 9'd511) state <= S_DRAIN;
        end
        S_DRAIN: begin
          cnt <= '0;
          if (!p1_vld && !p2_vld && !p3_done) state <= S_COL;
        end
        S_COL: begin
          if (cnt[2:0] == 3'd7) begin
            cnt   <= '0;
            state <= S_CWAIT;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        S_CWAIT: begin
          if (p3_done) state <= S_MUL;
        end
        S_MUL: begin
          num   <= acc * dc_weight(zu, zv);
          state <= S_PREP;
        end
        S_PREP: begin
          neg   <= num[NUM_W-1];
          nzero <= (num != '0);
          qz    <= (q == 8'd0);
          quo   <= tsum[NUM_W:QSH];
          rem   <= '0;
          dcnt  <= DCNT_W'(T_W);
          state <= (q == 8'd0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          rem   <= ge ? 8'(rem_sh - {1'b0, q}) : rem_sh[7:0];
          quo   <= {quo[T_W-2:0], ge};
          dcnt  <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) state <= S_FIN;
        end
        S_FIN: begin
          coef.coefficient     <= sat;
          coef.zigzag_position <= z;
          coef.block_end       <= (z == 6'd63);
          out_valid            <= 1'b1;
          state                <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (z == 6'd63) begin
              rel.bank <= bank;
              state    <= S_IDLE;
            end else begin
              z     <= z + 6'd1;
              state <= S_COL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/residual_dct8x8_quantizer_top_test.sv -----
// testbench for the residual 8x8 dct quantizer: predicted coefficients checked beat by beat
module residual_dct8x8_quantizer_top_test;
  import dct8q_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 700;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   coef;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  residual_dct8x8_quantizer_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .coef(coef),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0]         quant_words [NUM_QWORDS];
  logic signed [8:0]   residuals [64];
  int                  pair_count;
  out_beat_t           coef_queue [$];

  int error_count = 0;
  int blocks_sent;
  int coefs_checked = 0;
  int idle_cycles;
  bit calm;

  localparam logic [31:0] COS_MAG_Q30 [9] = '{
    32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
    32'd596538995, 32'd410903207, 32'd209476638, 32'd0
  };

  // cosine of (2x+1)u*pi/16 at COS_FRAC fractional bits
  function automatic longint dct_cosine(int x, int u);
    int     m;
    bit     neg;
    longint mag;
    m   = ((2 * x + 1) * u) % 32;
    neg = 1'b0;
    if (m > 16) m = 32 - m;
    if (m > 8) begin
      m   = 16 - m;
      neg = 1'b1;
    end
    mag = (longint'(COS_MAG_Q30[m]) + (longint'(1) << (29 - COS_FRAC))) >> (30 - COS_FRAC);
    return neg ? -mag : mag;
  endfunction

  function automatic longint round_away(longint v, int s);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (longint'(1) << (s - 1))) >> s;
    return v < 0 ? -mag : mag;
  endfunction

  // divide by quantizer, round half away from zero, saturate to 13 bits
  function automatic logic signed [12:0] quantize_coef(longint num, int q);
    longint unsigned mag, den, res;
    if (q == 0) begin
      if (num > 0) return COEF_MAX;
      if (num < 0) return COEF_MIN;
      return 13'sd0;
    end
    mag = num < 0 ? longint'(-num) : longint'(num);
    den = longint'(q) << (14 + 2 * COS_FRAC);
    res = (2 * mag + den) / (2 * den);
    if (num < 0) return res > 4096 ? COEF_MIN : -$signed(13'(res));
    return res > 4095 ? COEF_MAX : $signed(13'(res));
  endfunction

  // full block transform, pushes 64 expected beats in zigzag order
  task automatic predict_block();
    longint row_pass [8][8];
    longint acc, w;
    int     r, u, v, q;
    out_beat_t beat;
    for (int y = 0; y < 8; y++) begin
      for (int uu = 0; uu < 8; uu++) begin
        acc = 0;
        for (int x = 0; x < 8; x++) acc += longint'(residuals[y * 8 + x]) * dct_cosine(x, uu);
        if (COS_FRAC > ROW_FRAC) acc = round_away(acc, COS_FRAC - ROW_FRAC);
        else acc = acc * (longint'(1) << (ROW_FRAC - COS_FRAC));
        row_pass[uu][y] = acc;
      end
    end
    for (int z = 0; z < 64; z++) begin
      r = ZZ_TO_RASTER[z];
      v = r / 8;
      u = r % 8;
      q = quant_words[z / 8][8 * (z % 8) +: 8];
      acc = 0;
      for (int y = 0; y < 8; y++) acc += row_pass[u][y] * dct_cosine(y, v);
      if (u == 0 && v == 0) w = longint'(1) << (COS_FRAC - 1);
      else if (u == 0 || v == 0) w = dct_cosine(0, 4);
      else w = longint'(1) << COS_FRAC;
      beat.coefficient     = quantize_coef(acc * w, q);
      beat.zigzag_position = 6'(z);
      beat.block_end       = (z == 63);
      coef_queue.push_back(beat);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // send one pixel/prediction beat, with random gaps before it
  task automatic send_pair(logic [7:0] pix, logic [7:0] pred);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel: pix, predicted: pred};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    residuals[pair_count] = $signed({1'b0, pix}) - $signed({1'b0, pred});
    pair_count++;
    if (pair_count == 64) begin
      pair_count = 0;
      blocks_sent++;
      predict_block();
    end
  endtask

  // wait until every expected coefficient is out and the back end is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coef_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_quant(logic [63:0] words [NUM_QWORDS]);
    for (int i = 0; i < NUM_QWORDS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= words[i];
      quant_words[i] = words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_quant_fill(logic [63:0] word);
    logic [63:0] words [NUM_QWORDS];
    foreach (words[i]) words[i] = word;
    write_quant(words);
  endtask

  task automatic write_quant_random();
    logic [63:0] words [NUM_QWORDS];
    foreach (words[i]) words[i] = {$urandom, $urandom};
    write_quant(words);
  endtask

  task automatic send_flat_block(logic [7:0] pix, logic [7:0] pred);
    for (int i = 0; i < 64; i++) send_pair(pix, pred);
  endtask

  // full-scale residuals of both signs with the unit quantizer after reset
  task automatic test_extremes();
    send_flat_block(8'hFF, 8'h00);
    for (int i = 0; i < 64; i++)
      send_pair(((i / 8 + i % 8) % 2) ? 8'hFF : 8'h00, ((i / 8 + i % 8) % 2) ? 8'h00 : 8'hFF);
    wait_idle();
  endtask

  // zero quantizer entries mixed with the largest ones
  task automatic test_zero_quant();
    logic [63:0] words [NUM_QWORDS];
    foreach (words[i]) words[i] = (i % 2) ? 64'hFF00FF00FF00FF00 : 64'h00FF00FF00FF00FF;
    write_quant(words);
    for (int i = 0; i < 64; i++)
      send_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
    send_flat_block(8'h40, 8'h40);
    wait_idle();
  endtask

  // random blocks under random and largest quantizers, the second without gaps
  task automatic test_random_blocks();
    int mode;
    for (int phase = 0; phase < 2; phase++) begin
      if (phase == 0) write_quant_random();
      else write_quant_fill(64'hFFFFFFFFFFFFFFFF);
      calm = (phase == 1);
      mode = $urandom_range(2);
      for (int i = 0; i < 64; i++) begin
        logic [7:0] p;
        p = 8'($urandom_range(255));
        if (mode == 0) send_pair(p, 8'($urandom_range(255)));
        else if (mode == 1) send_pair(p, 8'(p + $urandom_range(8) - 4));
        else send_pair(8'((i % 8) * 32 + $urandom_range(15)), 8'((i / 8) * 30));
      end
      calm = 1'b0;
      wait_idle();
    end
  endtask

  // output side stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  // compare each coefficient beat with the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coef_queue.size() == 0) begin
        report_mismatch("unexpected beat, zigzag", coef.zigzag_position, -1);
      end else begin
        want = coef_queue.pop_front();
        coefs_checked++;
        if (coef.coefficient !== want.coefficient)
          report_mismatch("coefficient", coef.coefficient, want.coefficient);
        if (coef.zigzag_position !== want.zigzag_position)
          report_mismatch("zigzag_position", coef.zigzag_position, want.zigzag_position);
        if (coef.block_end !== want.block_end)
          report_mismatch("block_end", coef.block_end, want.block_end);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    blocks_sent = 0;
    pair_count  = 0;
    calm        = 1'b0;
    foreach (quant_words[i]) quant_words[i] = QUANT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_quant();
    test_random_blocks();
    wait_idle();
    $display("covered %0d blocks, %0d coefficient beats checked", blocks_sent, coefs_checked);
    $display("quantizer: unit, zero, 0xff, random and mixed settings; %0d mismatches",
             error_count);
    if (error_count == 0 && coef_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- residual_dct8x8_quantizer_top.f -----
hw/rtl/dct8q_pkg.sv
hw/rtl/dct8q_front.sv
hw/rtl/dct8q_queue.sv
hw/rtl/dct8q_back.sv
hw/rtl/residual_dct8x8_quantizer_top.sv
tb/residual_dct8x8_quantizer_top_test.sv
